@@ rtl/mqrd_pkg.sv @@
// ----------------------------------------------------------------------------
// mqrd_pkg
// Shared sizes, codes and the command request type for the multi-queue
// round dequeue block.
// ----------------------------------------------------------------------------
package mqrd_pkg;

  localparam int MAX_COUNTERS = 8;
  localparam int QUEUE_DEPTH  = 16;
  localparam int ID_BITS      = 16;

  localparam int CTR_W  = $clog2(MAX_COUNTERS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NCFG_W = 4;
  localparam int ADDR_W = CTR_W + PTR_W;
  localparam int MEM_DEPTH = MAX_COUNTERS * QUEUE_DEPTH;

  typedef enum logic [2:0] {
    STAT_ACCEPTED = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_BAD      = 3'd2,
    STAT_SERVED   = 3'd3,
    STAT_NONE     = 3'd4
  } status_t;

  // Classified request handed from front to back.
  typedef enum logic [1:0] {
    CMD_ENTER = 2'd0,
    CMD_BAD   = 2'd1,
    CMD_ROUND = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [CTR_W-1:0]     ctr;
    logic [ID_BITS-1:0]   id;
  } cmd_t;

endpackage

@@ rtl/mqrd_front.sv @@
// ----------------------------------------------------------------------------
// mqrd_front
// Holds the active-counter register and classifies each incoming request.
// ----------------------------------------------------------------------------
module mqrd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        kind,
  input  logic [mqrd_pkg::CTR_W-1:0]  counter_index,
  input  logic [mqrd_pkg::ID_BITS-1:0] passenger_id,
  input  logic                        cfg_write,
  input  logic [mqrd_pkg::NCFG_W-1:0] cfg_data,
  output logic                        push,
  output mqrd_pkg::cmd_t              cmd,
  output logic [mqrd_pkg::NCFG_W-1:0] active_n
);

  logic [mqrd_pkg::NCFG_W-1:0] counters_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      counters_in_use <= mqrd_pkg::NCFG_W'(mqrd_pkg::MAX_COUNTERS);
    end else if (cfg_write) begin
      counters_in_use <= cfg_data;
    end
  end

  // zero acts as one, anything above the counter count saturates
  always_comb begin
    if (counters_in_use == '0) begin
      active_n = mqrd_pkg::NCFG_W'(1);
    end else if (counters_in_use > mqrd_pkg::NCFG_W'(mqrd_pkg::MAX_COUNTERS)) begin
      active_n = mqrd_pkg::NCFG_W'(mqrd_pkg::MAX_COUNTERS);
    end else begin
      active_n = counters_in_use;
    end
  end

  assign push = start && !busy;

  always_comb begin
    cmd.ctr = counter_index;
    cmd.id  = passenger_id;
    if (kind) begin
      cmd.op = mqrd_pkg::CMD_ROUND;
    end else if (mqrd_pkg::NCFG_W'(counter_index) >= active_n) begin
      cmd.op = mqrd_pkg::CMD_BAD;
    end else begin
      cmd.op = mqrd_pkg::CMD_ENTER;
    end
  end

endmodule

@@ rtl/mqrd_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// mqrd_cmd_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module mqrd_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mqrd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output mqrd_pkg::cmd_t head_cmd
);

  mqrd_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/mqrd_back.sv @@
// ----------------------------------------------------------------------------
// mqrd_back
// Executes requests: queue store, per-counter pointers and the round scan.
// ----------------------------------------------------------------------------
module mqrd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  mqrd_pkg::cmd_t                cmd,
  input  logic [mqrd_pkg::NCFG_W-1:0]   active_n,
  output logic                          cmd_pop,
  output logic                          result_valid,
  output logic [2:0]                    status,
  output logic [mqrd_pkg::CTR_W-1:0]    out_counter,
  output logic [mqrd_pkg::ID_BITS-1:0]  served_id,
  output logic [mqrd_pkg::CNT_W-1:0]    still_waiting,
  output logic                          last
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                         state;
  logic [mqrd_pkg::CTR_W-1:0]     idx;
  logic [mqrd_pkg::PTR_W-1:0]     head_ptr      [mqrd_pkg::MAX_COUNTERS];
  logic [mqrd_pkg::PTR_W-1:0]     tail_ptr      [mqrd_pkg::MAX_COUNTERS];
  logic [mqrd_pkg::CNT_W-1:0]     waiting_count [mqrd_pkg::MAX_COUNTERS];
  logic [mqrd_pkg::ID_BITS-1:0]   queue_store   [mqrd_pkg::MEM_DEPTH];
  logic [mqrd_pkg::ID_BITS-1:0]   rd_data;
  mqrd_pkg::status_t              status_r;

  logic [mqrd_pkg::CTR_W-1:0]     sel;
  logic [mqrd_pkg::CNT_W-1:0]     sel_cnt;
  logic [mqrd_pkg::PTR_W-1:0]     sel_head;
  logic [mqrd_pkg::PTR_W-1:0]     sel_tail;
  logic [mqrd_pkg::MAX_COUNTERS-1:0] pending;
  logic [mqrd_pkg::MAX_COUNTERS-1:0] later;
  logic                           any_pending;
  logic                           more_after;
  logic                           idx_final;
  logic                           do_write;
  logic                           do_pop;

  // one pointer/count lookup per cycle: the scan index or the request's counter
  assign sel      = (state == S_SCAN) ? idx : cmd.ctr;
  assign sel_cnt  = waiting_count[sel];
  assign sel_head = head_ptr[sel];
  assign sel_tail = tail_ptr[sel];

  always_comb begin
    for (int j = 0; j < mqrd_pkg::MAX_COUNTERS; j++) begin
      pending[j] = (waiting_count[j] != '0) &&
                   (mqrd_pkg::NCFG_W'(j) < active_n);
      later[j]   = pending[j] && (mqrd_pkg::CTR_W'(j) > idx);
    end
  end

  assign any_pending = |pending;
  assign more_after  = |later;
  assign idx_final   = (mqrd_pkg::NCFG_W'(idx) + mqrd_pkg::NCFG_W'(1)) >= active_n;

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign do_write = cmd_pop && (cmd.op == mqrd_pkg::CMD_ENTER) &&
                    (sel_cnt != mqrd_pkg::CNT_W'(mqrd_pkg::QUEUE_DEPTH));
  assign do_pop   = (state == S_SCAN) && (sel_cnt != '0);

  function automatic logic [mqrd_pkg::PTR_W-1:0] next_slot(
    input logic [mqrd_pkg::PTR_W-1:0] p
  );
    if (p == mqrd_pkg::PTR_W'(mqrd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + mqrd_pkg::PTR_W'(1);
  endfunction

  // queue store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (do_write) begin
      queue_store[{sel, sel_tail}] <= cmd.id;
    end
    if (do_pop) begin
      rd_data <= queue_store[{sel, sel_head}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      result_valid  <= 1'b0;
      status_r      <= mqrd_pkg::STAT_NONE;
      out_counter   <= '0;
      still_waiting <= '0;
      last          <= 1'b0;
      for (int j = 0; j < mqrd_pkg::MAX_COUNTERS; j++) begin
        head_ptr[j]      <= '0;
        tail_ptr[j]      <= '0;
        waiting_count[j] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              mqrd_pkg::CMD_BAD: begin
                result_valid  <= 1'b1;
                status_r      <= mqrd_pkg::STAT_BAD;
                out_counter   <= cmd.ctr;
                still_waiting <= '0;
                last          <= 1'b1;
              end
              mqrd_pkg::CMD_ENTER: begin
                result_valid <= 1'b1;
                out_counter  <= cmd.ctr;
                last         <= 1'b1;
                if (do_write) begin
                  tail_ptr[sel]      <= next_slot(sel_tail);
                  waiting_count[sel] <= sel_cnt + mqrd_pkg::CNT_W'(1);
                  status_r           <= mqrd_pkg::STAT_ACCEPTED;
                  still_waiting      <= sel_cnt + mqrd_pkg::CNT_W'(1);
                end else begin
                  status_r      <= mqrd_pkg::STAT_FULL;
                  still_waiting <= sel_cnt;
                end
              end
              mqrd_pkg::CMD_ROUND: begin
                if (any_pending) begin
                  state <= S_SCAN;
                  idx   <= '0;
                end else begin
                  result_valid  <= 1'b1;
                  status_r      <= mqrd_pkg::STAT_NONE;
                  out_counter   <= '0;
                  still_waiting <= '0;
                  last          <= 1'b1;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          idx <= idx + mqrd_pkg::CTR_W'(1);
          if (do_pop) begin
            head_ptr[sel]      <= next_slot(sel_head);
            waiting_count[sel] <= sel_cnt - mqrd_pkg::CNT_W'(1);
            result_valid       <= 1'b1;
            status_r           <= mqrd_pkg::STAT_SERVED;
            out_counter        <= idx;
            still_waiting      <= sel_cnt - mqrd_pkg::CNT_W'(1);
            last               <= !more_after;
            if (!more_after) begin
              state <= S_IDLE;
            end
          end else if (idx_final) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status    = status_r;
  assign served_id = (status_r == mqrd_pkg::STAT_SERVED) ? rd_data : '0;

endmodule

@@ rtl/multi_queue_round_dequeue.sv @@
// ----------------------------------------------------------------------------
// multi_queue_round_dequeue
// One FIFO of passenger ids per service counter, with enter and round
// requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start while busy is low. kind 0 appends passenger_id to
//   queue counter_index; kind 1 runs a service round over the active counters.
//   The front classifies each request and places it in a two-entry queue;
//   busy is high while that queue is full and while rst is asserted.
//   Results appear on status/out_counter/served_id/still_waiting/last for one
//   cycle each, flagged by result_valid. The receiver cannot stall them.
//   An enter passes through the two-entry queue and then the back end's result
//   registers. A round scans one counter per cycle from counter 0, once the
//   back end takes it; it emits one result per non-empty active queue, last
//   set on the final one, or a single "none waiting" result. Enters are taken
//   at one request per cycle while no round is scanning; the back end takes
//   no new request until a round's scan is through.
//   cfg_write/cfg_data set counters_in_use (0 acts as 1, above 8 acts as 8);
//   write it only while no request is outstanding.
//   Reset empties all queues and sets counters_in_use to 8; the id store
//   itself is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module multi_queue_round_dequeue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [mqrd_pkg::CTR_W-1:0]    counter_index,
  input  logic [mqrd_pkg::ID_BITS-1:0]  passenger_id,
  input  logic                          cfg_write,
  input  logic [mqrd_pkg::NCFG_W-1:0]   cfg_data,
  output logic                          result_valid,
  output logic [2:0]                    status,
  output logic [mqrd_pkg::CTR_W-1:0]    out_counter,
  output logic [mqrd_pkg::ID_BITS-1:0]  served_id,
  output logic [mqrd_pkg::CNT_W-1:0]    still_waiting,
  output logic                          last
);

  logic                        push;
  mqrd_pkg::cmd_t              push_cmd;
  mqrd_pkg::cmd_t              head_cmd;
  logic                        q_full;
  logic                        q_not_empty;
  logic                        q_pop;
  logic [mqrd_pkg::NCFG_W-1:0] active_n;

  // busy reflects queue space (and reset); the back end drains independently
  assign busy = q_full || rst;

  mqrd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .counter_index (counter_index),
    .passenger_id  (passenger_id),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .push          (push),
    .cmd           (push_cmd),
    .active_n      (active_n)
  );

  mqrd_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  mqrd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_not_empty),
    .cmd           (head_cmd),
    .active_n      (active_n),
    .cmd_pop       (q_pop),
    .result_valid  (result_valid),
    .status        (status),
    .out_counter   (out_counter),
    .served_id     (served_id),
    .still_waiting (still_waiting),
    .last          (last)
  );

endmodule
